/* rtl/acps_pkg.sv */
// Shared constants and types for the alignment column pair scorer.
package acps_pkg;

  localparam int TEST_COLUMNS      = 4096;
  localparam int COL_W             = $clog2(TEST_COLUMNS);
  localparam int MAX_SEQUENCES_DEF = 1024;
  localparam int EPOCH_W           = 16;
  localparam int OUT_DEPTH         = 4;
  localparam int FIFO_CW           = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W             = $clog2(OUT_DEPTH);
  localparam int CP_W              = 19;
  localparam int LC_W              = 11;
  localparam int SUM48_W           = 48;
  localparam int SUM24_W           = 24;

  typedef struct packed {
    logic valid;
    logic clr;
  } sum_ctl_t;

  typedef struct packed {
    logic [CP_W-1:0]    column_correct_pairs;
    logic [COL_W-1:0]   best_column;
    logic               best_valid;
    logic [LC_W-1:0]    best_count;
    logic [LC_W-1:0]    letter_count;
    logic               column_fully_correct;
    logic [SUM48_W-1:0] sum_correct_pairs;
    logic [SUM48_W-1:0] sum_reference_pairs;
    logic [SUM24_W-1:0] sum_correct_columns;
  } result_t;

endpackage

/* rtl/acps_if.sv */
// Input and result channel interfaces of the alignment column pair scorer.
interface acps_in_if;
  import acps_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] test_column;
  logic             has_letter;
  logic             column_end;
  logic             new_run;
  modport source (output valid, test_column, has_letter, column_end, new_run, input ready);
  modport sink (input valid, test_column, has_letter, column_end, new_run, output ready);
endinterface

interface acps_out_if;
  import acps_pkg::*;
  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    column_correct_pairs;
  logic [COL_W-1:0]   best_column;
  logic               best_valid;
  logic [LC_W-1:0]    best_count;
  logic [LC_W-1:0]    letter_count;
  logic               column_fully_correct;
  logic [SUM48_W-1:0] sum_correct_pairs;
  logic [SUM48_W-1:0] sum_reference_pairs;
  logic [SUM24_W-1:0] sum_correct_columns;
  modport source (output valid, column_correct_pairs, best_column, best_valid, best_count,
                  letter_count, column_fully_correct, sum_correct_pairs,
                  sum_reference_pairs, sum_correct_columns, input ready);
  modport sink (input valid, column_correct_pairs, best_column, best_valid, best_count,
                letter_count, column_fully_correct, sum_correct_pairs,
                sum_reference_pairs, sum_correct_columns, output ready);
endinterface

/* rtl/alignment_column_pair_scorer_top.sv */
// Top level of the alignment column pair scorer.
//
// in_item carries one beat per matched sequence of a reference column: the test column
// holding its letter, a gap flag, the last-entry mark and the running-total clear.
// out_item carries one beat per reference column, issued for the beat with column_end
// set: correct pairs, best test column, fully-correct flag and the saturating totals.
// Throughput is one input beat per cycle while in_item.ready is high, set by one
// read-modify-write of the count memory per beat with forwarding from the previous
// write. A result passes through the s1 stage registers, the s2 summary registers
// and the result queue on its way to out_item. Per-column counts are tagged with a
// 16-bit column epoch, so finishing a column needs no clearing pass. After reset, and
// again after every 65535 columns, a clearing pass writes all 4096 entries, one per
// cycle; in_item.ready is low during the pass and in the cycle that ends the wrapping column.
// Results wait in a four-beat queue; in_item.ready drops when the results still in
// flight could fill it, so a stalled receiver loses nothing and throttles the input.
module alignment_column_pair_scorer_top #(
  parameter int MAX_SEQUENCES = acps_pkg::MAX_SEQUENCES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  acps_in_if.sink     in_item,
  acps_out_if.source  out_item
);
  import acps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1);
  localparam int PAIR_W = $clog2(longint'(MAX_SEQUENCES) * longint'(MAX_SEQUENCES - 1) / 2 + 1);

  sum_ctl_t            sum_ctl;
  logic [PAIR_W-1:0]   sum_pairs, sum_ref_pairs;
  logic [CNT_W-1:0]    sum_letters, sum_best_count;
  logic [COL_W-1:0]    sum_best_column;
  logic [FIFO_CW-1:0]  free_slots;
  logic                s2_busy, push;
  result_t             result, out_data;

  acps_column #(
    .MAX_SEQUENCES(MAX_SEQUENCES)
  ) u_column (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_item.valid),
    .in_ready        (in_item.ready),
    .in_col          (in_item.test_column),
    .in_has          (in_item.has_letter),
    .in_end          (in_item.column_end),
    .in_new          (in_item.new_run),
    .free_slots      (free_slots),
    .s2_busy         (s2_busy),
    .sum_ctl         (sum_ctl),
    .sum_pairs       (sum_pairs),
    .sum_ref_pairs   (sum_ref_pairs),
    .sum_letters     (sum_letters),
    .sum_best_count  (sum_best_count),
    .sum_best_column (sum_best_column)
  );

  acps_totals #(
    .MAX_SEQUENCES(MAX_SEQUENCES)
  ) u_totals (
    .clk             (clk),
    .rst_n           (rst_n),
    .sum_ctl         (sum_ctl),
    .sum_pairs       (sum_pairs),
    .sum_ref_pairs   (sum_ref_pairs),
    .sum_letters     (sum_letters),
    .sum_best_count  (sum_best_count),
    .sum_best_column (sum_best_column),
    .s2_busy         (s2_busy),
    .push            (push),
    .result          (result)
  );

  acps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result),
    .pop        (out_item.ready),
    .out_valid  (out_item.valid),
    .out_data   (out_data),
    .free_slots (free_slots)
  );

  assign out_item.column_correct_pairs = out_data.column_correct_pairs;
  assign out_item.best_column          = out_data.best_column;
  assign out_item.best_valid           = out_data.best_valid;
  assign out_item.best_count           = out_data.best_count;
  assign out_item.letter_count         = out_data.letter_count;
  assign out_item.column_fully_correct = out_data.column_fully_correct;
  assign out_item.sum_correct_pairs    = out_data.sum_correct_pairs;
  assign out_item.sum_reference_pairs  = out_data.sum_reference_pairs;
  assign out_item.sum_correct_columns  = out_data.sum_correct_columns;
endmodule

/* rtl/acps_ram.sv */
// Generic simple dual-port RAM with registered read.
module acps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

/* rtl/acps_column.sv */
// Per-column counting stage: count store read-modify-write, pair sums and leader tracking.
module acps_column #(
  parameter int MAX_SEQUENCES = acps_pkg::MAX_SEQUENCES_DEF,
  localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1),
  localparam int PAIR_W = $clog2(longint'(MAX_SEQUENCES) * longint'(MAX_SEQUENCES - 1) / 2 + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [acps_pkg::COL_W-1:0]    in_col,
  input  logic                          in_has,
  input  logic                          in_end,
  input  logic                          in_new,
  input  logic [acps_pkg::FIFO_CW-1:0]  free_slots,
  input  logic                          s2_busy,
  output acps_pkg::sum_ctl_t            sum_ctl,
  output logic [PAIR_W-1:0]             sum_pairs,
  output logic [PAIR_W-1:0]             sum_ref_pairs,
  output logic [CNT_W-1:0]              sum_letters,
  output logic [CNT_W-1:0]              sum_best_count,
  output logic [acps_pkg::COL_W-1:0]    sum_best_column
);
  import acps_pkg::*;

  localparam int RANK_W = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int WORD_W = EPOCH_W + RANK_W + CNT_W;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  logic                sweep_r, sweep_nxt;
  logic [COL_W-1:0]    sweep_addr_r, sweep_addr_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;

  logic                s1_valid_r;
  logic [COL_W-1:0]    s1_col_r;
  logic                s1_has_r, s1_end_r, s1_new_r;

  logic                fwd_valid_r, fwd_valid_nxt;
  logic [COL_W-1:0]    fwd_addr_r;
  logic [WORD_W-1:0]   fwd_data_r;

  logic [CNT_W-1:0]    letters_r, letters_nxt, letters_upd;
  logic [CNT_W-1:0]    distinct_r, distinct_nxt, distinct_upd;
  logic [PAIR_W-1:0]   pairs_r, pairs_nxt, pairs_upd;
  logic [PAIR_W-1:0]   ref_pairs_r, ref_pairs_nxt, ref_pairs_upd;
  logic [COL_W-1:0]    lead_col_r, lead_col_nxt, lead_col_upd;
  logic [CNT_W-1:0]    lead_cnt_r, lead_cnt_nxt, lead_cnt_upd;
  logic [RANK_W-1:0]   lead_rank_r, lead_rank_nxt, lead_rank_upd;
  logic                clr_pend_r, clr_pend_nxt, clr_upd;

  logic                accept, counted, end_fire, wrap_pend, take;
  logic [FIFO_CW-1:0]  need;
  logic [WORD_W-1:0]   rdata, word, new_word;
  logic [CNT_W-1:0]    cur_cnt, c_new;
  logic [RANK_W-1:0]   rank;
  logic                ram_we;
  logic [COL_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  acps_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TEST_COLUMNS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_col),
    .rdata (rdata)
  );

  assign end_fire  = s1_valid_r & s1_end_r;
  assign wrap_pend = end_fire & (epoch_r == EPOCH_LAST);
  assign need      = FIFO_CW'(s2_busy) + FIFO_CW'(end_fire);
  assign in_ready  = !sweep_r && !wrap_pend && (free_slots > need);
  assign accept    = in_valid & in_ready;

  always_comb begin
    word     = (fwd_valid_r && fwd_addr_r == s1_col_r) ? fwd_data_r : rdata;
    cur_cnt  = (word[WORD_W-1 -: EPOCH_W] == epoch_r) ? word[CNT_W-1:0] : '0;
    rank     = (cur_cnt == '0) ? RANK_W'(distinct_r) : word[CNT_W +: RANK_W];
    c_new    = cur_cnt + CNT_W'(1);
    counted  = s1_valid_r && s1_has_r && (letters_r < CNT_W'(MAX_SEQUENCES));
    new_word = {epoch_r, rank, c_new};
    take     = counted &&
               ((c_new > lead_cnt_r) || (c_new == lead_cnt_r && rank < lead_rank_r));

    letters_upd   = counted ? letters_r + CNT_W'(1) : letters_r;
    distinct_upd  = (counted && cur_cnt == '0) ? distinct_r + CNT_W'(1) : distinct_r;
    pairs_upd     = counted ? pairs_r + PAIR_W'(cur_cnt) : pairs_r;
    ref_pairs_upd = counted ? ref_pairs_r + PAIR_W'(letters_r) : ref_pairs_r;
    lead_col_upd  = take ? s1_col_r : lead_col_r;
    lead_cnt_upd  = take ? c_new : lead_cnt_r;
    lead_rank_upd = take ? rank : lead_rank_r;
    clr_upd       = clr_pend_r | (s1_valid_r & s1_new_r);

    ram_we    = sweep_r | counted;
    ram_waddr = sweep_r ? sweep_addr_r : s1_col_r;
    ram_wdata = sweep_r ? '0 : new_word;

    sum_ctl.valid   = end_fire;
    sum_ctl.clr     = clr_upd;
    sum_pairs       = pairs_upd;
    sum_ref_pairs   = ref_pairs_upd;
    sum_letters     = letters_upd;
    sum_best_count  = lead_cnt_upd;
    sum_best_column = lead_col_upd;

    sweep_nxt      = sweep_r;
    sweep_addr_nxt = sweep_addr_r;
    epoch_nxt      = epoch_r;
    fwd_valid_nxt  = fwd_valid_r;
    if (sweep_r) begin
      sweep_addr_nxt = sweep_addr_r + COL_W'(1);
      fwd_valid_nxt  = 1'b0;
      if (sweep_addr_r == '1) begin
        sweep_nxt = 1'b0;
      end
    end else if (counted) begin
      fwd_valid_nxt = 1'b1;
    end
    if (end_fire) begin
      if (epoch_r == EPOCH_LAST) begin
        sweep_nxt      = 1'b1;
        sweep_addr_nxt = '0;
        epoch_nxt      = EPOCH_FIRST;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end

    if (end_fire) begin
      letters_nxt   = '0;
      distinct_nxt  = '0;
      pairs_nxt     = '0;
      ref_pairs_nxt = '0;
      lead_col_nxt  = '0;
      lead_cnt_nxt  = '0;
      lead_rank_nxt = '0;
      clr_pend_nxt  = 1'b0;
    end else begin
      letters_nxt   = letters_upd;
      distinct_nxt  = distinct_upd;
      pairs_nxt     = pairs_upd;
      ref_pairs_nxt = ref_pairs_upd;
      lead_col_nxt  = lead_col_upd;
      lead_cnt_nxt  = lead_cnt_upd;
      lead_rank_nxt = lead_rank_upd;
      clr_pend_nxt  = clr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      epoch_r      <= EPOCH_FIRST;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      letters_r    <= '0;
      distinct_r   <= '0;
      pairs_r      <= '0;
      ref_pairs_r  <= '0;
      lead_col_r   <= '0;
      lead_cnt_r   <= '0;
      lead_rank_r  <= '0;
      clr_pend_r   <= 1'b0;
    end else begin
      sweep_r      <= sweep_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      epoch_r      <= epoch_nxt;
      s1_valid_r   <= accept;
      fwd_valid_r  <= fwd_valid_nxt;
      letters_r    <= letters_nxt;
      distinct_r   <= distinct_nxt;
      pairs_r      <= pairs_nxt;
      ref_pairs_r  <= ref_pairs_nxt;
      lead_col_r   <= lead_col_nxt;
      lead_cnt_r   <= lead_cnt_nxt;
      lead_rank_r  <= lead_rank_nxt;
      clr_pend_r   <= clr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= in_col;
      s1_has_r <= in_has;
      s1_end_r <= in_end;
      s1_new_r <= in_new;
    end
    if (counted) begin
      fwd_addr_r <= s1_col_r;
      fwd_data_r <= new_word;
    end
  end
endmodule

/* rtl/acps_totals.sv */
// Column summary stage: per-column flags and saturating running totals.
module acps_totals #(
  parameter int MAX_SEQUENCES = acps_pkg::MAX_SEQUENCES_DEF,
  localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1),
  localparam int PAIR_W = $clog2(longint'(MAX_SEQUENCES) * longint'(MAX_SEQUENCES - 1) / 2 + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  acps_pkg::sum_ctl_t          sum_ctl,
  input  logic [PAIR_W-1:0]           sum_pairs,
  input  logic [PAIR_W-1:0]           sum_ref_pairs,
  input  logic [CNT_W-1:0]            sum_letters,
  input  logic [CNT_W-1:0]            sum_best_count,
  input  logic [acps_pkg::COL_W-1:0]  sum_best_column,
  output logic                        s2_busy,
  output logic                        push,
  output acps_pkg::result_t           result
);
  import acps_pkg::*;

  logic                s2_valid_r;
  logic                s2_clr_r;
  logic [PAIR_W-1:0]   s2_pairs_r, s2_ref_pairs_r;
  logic [CNT_W-1:0]    s2_letters_r, s2_best_count_r;
  logic [COL_W-1:0]    s2_best_column_r;

  logic [SUM48_W-1:0]  tot_c_r, tot_c_nxt, base_c;
  logic [SUM48_W-1:0]  tot_ref_r, tot_ref_nxt, base_ref;
  logic [SUM24_W-1:0]  tot_f_r, tot_f_nxt, base_f;
  logic [SUM48_W:0]    add_c, add_ref;
  logic                best_valid, full;

  always_comb begin
    base_c   = s2_clr_r ? '0 : tot_c_r;
    base_ref = s2_clr_r ? '0 : tot_ref_r;
    base_f   = s2_clr_r ? '0 : tot_f_r;
    add_c    = (SUM48_W + 1)'(base_c) + (SUM48_W + 1)'(s2_pairs_r);
    add_ref  = (SUM48_W + 1)'(base_ref) + (SUM48_W + 1)'(s2_ref_pairs_r);
    full       = (s2_pairs_r == s2_ref_pairs_r);
    best_valid = (s2_best_count_r > (s2_letters_r >> 1));

    tot_c_nxt   = add_c[SUM48_W] ? '1 : add_c[SUM48_W-1:0];
    tot_ref_nxt = add_ref[SUM48_W] ? '1 : add_ref[SUM48_W-1:0];
    tot_f_nxt   = (full && base_f != '1) ? base_f + SUM24_W'(1) : base_f;

    result.column_correct_pairs = CP_W'(s2_pairs_r);
    result.best_column          = best_valid ? s2_best_column_r : '0;
    result.best_valid           = best_valid;
    result.best_count           = LC_W'(s2_best_count_r);
    result.letter_count         = LC_W'(s2_letters_r);
    result.column_fully_correct = full;
    result.sum_correct_pairs    = tot_c_nxt;
    result.sum_reference_pairs  = tot_ref_nxt;
    result.sum_correct_columns  = tot_f_nxt;
  end

  assign s2_busy = s2_valid_r;
  assign push    = s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      tot_c_r    <= '0;
      tot_ref_r  <= '0;
      tot_f_r    <= '0;
    end else begin
      s2_valid_r <= sum_ctl.valid;
      if (s2_valid_r) begin
        tot_c_r   <= tot_c_nxt;
        tot_ref_r <= tot_ref_nxt;
        tot_f_r   <= tot_f_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ctl.valid) begin
      s2_clr_r         <= sum_ctl.clr;
      s2_pairs_r       <= sum_pairs;
      s2_ref_pairs_r   <= sum_ref_pairs;
      s2_letters_r     <= sum_letters;
      s2_best_count_r  <= sum_best_count;
      s2_best_column_r <= sum_best_column;
    end
  end
endmodule

/* rtl/acps_fifo.sv */
// Result queue between the summary stage and the output channel.
module acps_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  acps_pkg::result_t             push_data,
  input  logic                          pop,
  output logic                          out_valid,
  output acps_pkg::result_t             out_data,
  output logic [acps_pkg::FIFO_CW-1:0]  free_slots
);
  import acps_pkg::*;

  result_t            mem_r [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_pop;

  assign out_valid  = (count_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign do_pop     = pop & out_valid;
  assign free_slots = FIFO_CW'(OUT_DEPTH) - count_r;

  always_comb begin
    count_nxt = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + FIFO_CW'(1);
      2'b01:   count_nxt = count_r - FIFO_CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

/* verif/alignment_column_pair_scorer_top_test.sv */
// Self-checking testbench: scores random and directed sequence entries and compares results.
module alignment_column_pair_scorer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acps_pkg::*;

  localparam int MAX_LETTERS  = MAX_SEQUENCES_DEF;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_AFTER   = 80;
  localparam int LONG_COLUMN  = 1030;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_TAIL   = 100;
  localparam int STALL_LIMIT  = 20000;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [COL_W-1:0] test_column;
    logic             has_letter;
    logic             column_end;
    logic             new_run;
  } sequence_entry_t;

  logic clk;
  logic rst_n;

  acps_in_if  in_item ();
  acps_out_if out_item ();

  alignment_column_pair_scorer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  sequence_entry_t entry_q[$];
  result_t         column_scores_due[$];

  // per-column tallies and running totals
  logic [LC_W-1:0]    tally [TEST_COLUMNS];
  logic [9:0]         first_rank [TEST_COLUMNS];
  logic [LC_W-1:0]    letters;
  logic [LC_W-1:0]    distinct;
  logic [19:0]        pairs;
  logic [COL_W-1:0]   lead_column;
  logic [LC_W-1:0]    lead_count;
  logic [9:0]         lead_rank;
  logic [SUM48_W-1:0] run_correct;
  logic [SUM48_W-1:0] run_reference;
  logic [SUM24_W-1:0] run_full;

  int  mismatches;
  int  columns_checked;
  int  entries_taken;
  int  hold_point;
  int  stalled;
  int  in_gap, in_calm, out_gap, out_calm, hold_left;
  bit  hold_done;
  bit  in_beat_taken, out_beat_taken;

  function automatic bit score_entry(input sequence_entry_t e, output result_t r);
    longint unsigned    lc;
    longint unsigned    ref_pairs;
    logic [SUM48_W:0]   s;
    logic [LC_W-1:0]    c;
    logic [9:0]         rk;
    bit                 best_ok;
    bit                 full;
    r = '0;
    if (e.new_run) begin
      run_correct   = '0;
      run_reference = '0;
      run_full      = '0;
    end
    if (e.has_letter && letters < MAX_LETTERS) begin
      c = tally[e.test_column];
      if (c == 0) begin
        first_rank[e.test_column] = distinct[9:0];
        distinct++;
      end
      rk = first_rank[e.test_column];
      pairs += c;
      c++;
      tally[e.test_column] = c;
      letters++;
      if (c > lead_count || (c == lead_count && rk < lead_rank)) begin
        lead_column = e.test_column;
        lead_count  = c;
        lead_rank   = rk;
      end
    end
    if (!e.column_end) return 1'b0;
    lc        = letters;
    ref_pairs = (lc == 0) ? 0 : (lc * (lc - 1)) / 2;
    best_ok   = lead_count > (letters >> 1);
    full      = (pairs == ref_pairs);
    s = {1'b0, run_correct} + pairs;
    run_correct = s[SUM48_W] ? '1 : s[SUM48_W-1:0];
    s = {1'b0, run_reference} + ref_pairs;
    run_reference = s[SUM48_W] ? '1 : s[SUM48_W-1:0];
    if (full && run_full != '1) run_full++;
    r.column_correct_pairs = pairs[CP_W-1:0];
    r.best_column          = best_ok ? lead_column : '0;
    r.best_valid           = best_ok;
    r.best_count           = lead_count;
    r.letter_count         = letters;
    r.column_fully_correct = full;
    r.sum_correct_pairs    = run_correct;
    r.sum_reference_pairs  = run_reference;
    r.sum_correct_columns  = run_full;
    foreach (tally[i]) tally[i] = '0;
    letters     = '0;
    distinct    = '0;
    pairs       = '0;
    lead_column = '0;
    lead_count  = '0;
    lead_rank   = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH result %0d %s: got %0d expected %0d", columns_checked, what, got,
               want);
  endtask

  task automatic check_field(string what, logic [SUM48_W-1:0] got, logic [SUM48_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic add_entry(int col, bit has, bit last, bit clr);
    sequence_entry_t e;
    e.test_column = col[COL_W-1:0];
    e.has_letter  = has;
    e.column_end  = last;
    e.new_run     = clr;
    entry_q = {entry_q, e};
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sample both channels, predict, compare and watch for a hang
  always @(posedge clk) begin
    sequence_entry_t e;
    result_t         want;
    bit              emits;
    in_beat_taken  = rst_n && in_item.valid && in_item.ready;
    out_beat_taken = rst_n && out_item.valid && out_item.ready;
    if (in_beat_taken) begin
      e.test_column = in_item.test_column;
      e.has_letter  = in_item.has_letter;
      e.column_end  = in_item.column_end;
      e.new_run     = in_item.new_run;
      emits = score_entry(e, want);
      if (emits) column_scores_due = {column_scores_due, want};
      entries_taken++;
    end
    if (out_beat_taken) begin
      if (column_scores_due.size() == 0) begin
        report_mismatch("result with none pending", 0, 0);
      end else begin
        want = column_scores_due.pop_front();
        check_field("column_correct_pairs", out_item.column_correct_pairs,
                    want.column_correct_pairs);
        check_field("best_column", out_item.best_column, want.best_column);
        check_field("best_valid", out_item.best_valid, want.best_valid);
        check_field("best_count", out_item.best_count, want.best_count);
        check_field("letter_count", out_item.letter_count, want.letter_count);
        check_field("column_fully_correct", out_item.column_fully_correct,
                    want.column_fully_correct);
        check_field("sum_correct_pairs", out_item.sum_correct_pairs,
                    want.sum_correct_pairs);
        check_field("sum_reference_pairs", out_item.sum_reference_pairs,
                    want.sum_reference_pairs);
        check_field("sum_correct_columns", out_item.sum_correct_columns,
                    want.sum_correct_columns);
      end
      columns_checked++;
    end
    if (!rst_n || in_beat_taken || out_beat_taken) stalled = 0;
    else stalled++;
    if (stalled == STALL_LIMIT) begin
      $display("alignment_column_pair_scorer_top_test NOT OK");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    sequence_entry_t e;
    if (rst_n && (!in_item.valid || in_beat_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_item.valid <= 1'b0;
      end else if (entry_q.size() == 0) begin
        in_item.valid <= 1'b0;
      end else if (entry_q.size() > QUIET_TAIL && in_calm == 0 &&
                   $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 13);
        in_item.valid <= 1'b0;
      end else begin
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(30, 120);
        e = entry_q.pop_front();
        in_item.test_column <= e.test_column;
        in_item.has_letter  <= e.has_letter;
        in_item.column_end  <= e.column_end;
        in_item.new_run     <= e.new_run;
        in_item.valid       <= 1'b1;
      end
    end
  end

  // result receiver: random stalls, one long hold-off, none in the tail
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_item.ready <= 1'b0;
    end else if (!hold_done && entries_taken >= hold_point) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_item.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_item.ready <= 1'b0;
    end else if (entry_q.size() > QUIET_TAIL && out_calm == 0 &&
                 $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(0, 13);
      out_item.ready <= 1'b0;
    end else begin
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 59) == 0) out_calm = $urandom_range(30, 150);
      out_item.ready <= 1'b1;
    end
  end

  initial begin
    int random_items;
    int len;
    int npool;
    int pool [8];
    int col;
    bit has;
    bit clr;
    rst_n               = 1'b0;
    in_item.valid       = 1'b0;
    in_item.test_column = '0;
    in_item.has_letter  = 1'b0;
    in_item.column_end  = 1'b0;
    in_item.new_run     = 1'b0;
    out_item.ready      = 1'b0;
    foreach (tally[i]) tally[i] = '0;
    foreach (first_rank[i]) first_rank[i] = '0;
    letters = '0; distinct = '0; pairs = '0;
    lead_column = '0; lead_count = '0; lead_rank = '0;
    run_correct = '0; run_reference = '0; run_full = '0;

    // empty column: a lone gap with junk column, with a new run
    add_entry(12'hABC, 0, 1, 1);
    // single letter at the top column
    add_entry(12'hFFF, 1, 1, 0);
    // two letters, tie between extremes
    add_entry(12'hFFF, 1, 0, 0);
    add_entry(12'h000, 1, 1, 0);
    // tie of two pairs with a gap inside
    add_entry(12'h555, 1, 0, 0);
    add_entry(12'hAAA, 1, 0, 0);
    add_entry(12'hAAA, 1, 0, 0);
    add_entry(12'h555, 0, 0, 0);
    add_entry(12'h555, 1, 1, 0);
    // clear majority, later column overtakes
    add_entry(12'h123, 1, 0, 0);
    add_entry(12'h456, 1, 0, 0);
    add_entry(12'h456, 1, 0, 0);
    add_entry(12'h456, 1, 1, 0);
    // new run in the middle of a column
    add_entry(12'h7FF, 1, 0, 0);
    add_entry(12'h800, 1, 0, 1);
    add_entry(12'h7FF, 1, 1, 0);
    // gaps only
    add_entry(12'hFFF, 0, 0, 0);
    add_entry(12'h000, 0, 1, 0);
    // fully correct column, new run on its last entry
    add_entry(12'h0F0, 1, 0, 0);
    add_entry(12'h0F0, 1, 0, 0);
    add_entry(12'h0F0, 1, 1, 1);

    // letters beyond the per-column limit are dropped
    for (int i = 0; i < LONG_COLUMN; i++)
      add_entry(i < MAX_LETTERS ? 12'h9C3 : $urandom_range(0, 4095), 1,
                i == LONG_COLUMN - 1, 0);

    random_items = 0;
    hold_point = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        len   = $urandom_range(10, 40);
        npool = 8;
      end else begin
        len   = $urandom_range(1, 12);
        npool = $urandom_range(1, 4);
      end
      for (int k = 0; k < npool; k++) pool[k] = $urandom_range(0, 4095);
      for (int i = 0; i < len; i++) begin
        has = $urandom_range(0, 7) != 0;
        clr = $urandom_range(0, 39) == 0;
        if (!has) col = $urandom_range(0, 4095);
        else if ($urandom_range(0, 3) == 0) col = pool[$urandom_range(0, npool - 1)];
        else col = pool[0];
        add_entry(col, has, i == len - 1, clr);
        random_items++;
      end
      if (hold_point == 0 && random_items >= HOLD_AFTER) hold_point = entry_q.size();
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (entry_q.size() != 0 || in_item.valid || column_scores_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("alignment_column_pair_scorer_top_test OK");
    end else begin
      $display("alignment_column_pair_scorer_top_test NOT OK");
    end
    $finish;
  end

endmodule
